// ===== rtl/lbts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_pkg
// Shared types and constants of the lower bound time stamp clock table.
// ----------------------------------------------------------------------------
package lbts_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int HANDLE_W    = 16;
	localparam int TIME_W      = 48;
	localparam int ENTRY_W     = HANDLE_W + TIME_W;

	localparam logic [TIME_W-1:0]   INF_TIME    = {TIME_W{1'b1}};
	localparam logic [HANDLE_W-1:0] ANON_HANDLE = '0;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic scan_en;
		logic commit;
	} lbts_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} lbts_stat_t;

endpackage

// ===== rtl/lbts_clock_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_clock_table
// Participant clock table with lower bound time stamp computation.
// ----------------------------------------------------------------------------
// One request at a time: each request makes one pass over the entry table
// through its single registered read port before its result is committed. A
// finished result sits in an output register, so the next request is taken
// while it waits; commit of that next request stalls only if the old result
// is still not taken. The entry table needs no clearing pass after reset.
module lbts_clock_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lbts_pkg::HANDLE_W-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [lbts_pkg::HANDLE_W-1:0] handle,
	input  logic [lbts_pkg::TIME_W-1:0]   time_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic                          present,
	output logic [lbts_pkg::TIME_W-1:0]   lower_bound,
	output logic                          anonymous_seen
);
	import lbts_pkg::*;

	lbts_cmd_t  cmd;
	lbts_stat_t stat;

	lbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lbts_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.operation      (operation),
		.handle         (handle),
		.time_value     (time_value),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.present        (present),
		.lower_bound    (lower_bound),
		.anonymous_seen (anonymous_seen)
	);

endmodule

// ===== rtl/lbts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_ctrl
// Sequencer: accept a request, scan the table, commit the result.
// ----------------------------------------------------------------------------
module lbts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lbts_pkg::lbts_stat_t stat,
	output lbts_pkg::lbts_cmd_t  cmd
);
	import lbts_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.start   = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lbts_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_dpath
// Entry table, scan accumulators, commit logic and result register.
// ----------------------------------------------------------------------------
module lbts_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lbts_pkg::HANDLE_W-1:0] cfg_wr_data,
	input  logic [1:0]                    operation,
	input  logic [lbts_pkg::HANDLE_W-1:0] handle,
	input  logic [lbts_pkg::TIME_W-1:0]   time_value,
	input  lbts_pkg::lbts_cmd_t           cmd,
	output lbts_pkg::lbts_stat_t          stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic                          present,
	output logic [lbts_pkg::TIME_W-1:0]   lower_bound,
	output logic                          anonymous_seen
);
	import lbts_pkg::*;

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH);

	// request and configuration
	op_t                 op_q;
	logic [HANDLE_W-1:0] hdl_q;
	logic [TIME_W-1:0]   tim_q;
	logic [HANDLE_W-1:0] own_q;

	// table
	logic [ENTRY_W-1:0]     entry_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	// scan
	logic [CNT_W-1:0]   idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rd_data_s1;

	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [TIME_W-1:0] match_time_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [TIME_W-1:0] min_excl_q;
	logic              anon_q;

	// result
	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_present_q;
	logic [TIME_W-1:0] out_bound_q;
	logic              out_anon_q;

	logic [HANDLE_W-1:0] rd_hdl;
	logic [TIME_W-1:0]   rd_time;
	logic                ent_valid;
	logic                anon_op;
	logic [TIME_W-1:0]   cur_time;
	logic                hit;
	logic                elig;
	logic                scan_wr;

	logic              own_match;
	logic [TIME_W-1:0] min_all;
	logic [TIME_W-1:0] upd_time;
	status_t           fin_status;
	logic [TIME_W-1:0] fin_bound;
	logic              fin_wr;
	logic [IDX_W-1:0]  fin_addr;
	logic [ENTRY_W-1:0] fin_data;
	logic              fin_set;
	logic              fin_clr;
	logic              fin_anon;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_wr_en) begin
			own_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op_t'(operation);
			hdl_q <= handle;
			tim_q <= time_value;
		end
	end

	// scan address and registered table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_en && (idx_q != LAST_CNT);
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.scan_en && (idx_q != LAST_CNT)) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= entry_mem[idx_q[IDX_W-1:0]];
		rd_idx_s1  <= idx_q[IDX_W-1:0];
	end

	assign stat.scan_done = (idx_q == LAST_CNT) && !rd_vld_s1;
	assign stat.out_busy  = out_valid_q && !out_ready;

	// per-entry evaluation
	always_comb begin
		rd_hdl    = rd_data_s1[ENTRY_W-1:TIME_W];
		rd_time   = rd_data_s1[TIME_W-1:0];
		ent_valid = valid_q[rd_idx_s1];
		anon_op   = (op_q == OP_UPDATE) && (hdl_q == ANON_HANDLE);
		cur_time  = (anon_op && (rd_time <= tim_q)) ? tim_q : rd_time;
		hit       = rd_vld_s1 && ent_valid && (rd_hdl == hdl_q);
		elig      = rd_vld_s1 && ent_valid && (rd_hdl != own_q);
		scan_wr   = rd_vld_s1 && ent_valid && anon_op && (rd_time <= tim_q);
	end

	// match, first free slot, minimum over valid entries other than the match and own handle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			min_excl_q    <= INF_TIME;
		end else if (cmd.start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			min_excl_q    <= INF_TIME;
		end else if (rd_vld_s1) begin
			if (hit) begin
				match_found_q <= 1'b1;
			end else if (elig && (cur_time < min_excl_q)) begin
				min_excl_q <= cur_time;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			match_idx_q  <= rd_idx_s1;
			match_time_q <= cur_time;
		end
		if (rd_vld_s1 && !ent_valid && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// commit
	always_comb begin
		own_match  = (hdl_q == own_q);
		min_all    = (match_found_q && !own_match && (match_time_q < min_excl_q)) ?
			match_time_q : min_excl_q;
		upd_time   = (match_time_q <= tim_q) ? tim_q : match_time_q;
		fin_status = ST_OK;
		fin_bound  = min_all;
		fin_wr     = 1'b0;
		fin_addr   = match_idx_q;
		fin_data   = {hdl_q, upd_time};
		fin_set    = 1'b0;
		fin_clr    = 1'b0;
		fin_anon   = anon_q;
		unique case (op_q)
			OP_INSERT: begin
				if (match_found_q) begin
					fin_status = ST_PRESENT;
				end else if (!free_found_q) begin
					fin_status = ST_FULL;
				end else begin
					fin_wr    = 1'b1;
					fin_set   = 1'b1;
					fin_addr  = free_idx_q;
					fin_data  = {hdl_q, tim_q};
					fin_bound = (!own_match && (tim_q < min_excl_q)) ? tim_q : min_excl_q;
				end
			end
			OP_UPDATE: begin
				if (hdl_q == ANON_HANDLE) begin
					fin_anon = 1'b1;
				end else if (!match_found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					fin_wr    = 1'b1;
					fin_bound = (!own_match && (upd_time < min_excl_q)) ?
						upd_time : min_excl_q;
				end
			end
			OP_REMOVE: begin
				if (!match_found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					fin_clr   = 1'b1;
					fin_bound = min_excl_q;
				end
			end
			OP_QUERY: begin
				fin_status = ST_OK;
			end
			default: begin
				fin_status = ST_OK;
			end
		endcase
	end

	// single write port, shared by anonymous raise and commit
	always_comb begin
		wr_en   = scan_wr || (cmd.commit && fin_wr);
		wr_addr = scan_wr ? rd_idx_s1 : fin_addr;
		wr_data = scan_wr ? {rd_hdl, tim_q} : fin_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			anon_q  <= 1'b0;
		end else if (cmd.commit) begin
			anon_q <= fin_anon;
			if (fin_set) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (fin_clr) begin
				valid_q[match_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_anon_q  <= 1'b0;
			out_bound_q <= INF_TIME;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
			out_anon_q  <= fin_anon;
			out_bound_q <= fin_bound;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q  <= fin_status;
			out_present_q <= match_found_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign present        = out_present_q;
	assign lower_bound    = out_bound_q;
	assign anonymous_seen = out_anon_q;

endmodule

// ===== rtl/lbts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_checker
// Port-level checks of the clock table, bound to the top level.
// ----------------------------------------------------------------------------
module lbts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [1:0]                    operation,
	input logic [lbts_pkg::HANDLE_W-1:0] handle,
	input logic [lbts_pkg::TIME_W-1:0]   time_value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    status,
	input logic                          present,
	input logic [lbts_pkg::TIME_W-1:0]   lower_bound,
	input logic                          anonymous_seen
);
	import lbts_pkg::*;

	// one request in flight: ready drops after an accept
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while one is in flight");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(handle) &&
			$stable(time_value))
		else $error("request changed before it was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lower_bound) && $stable(status))
		else $error("result changed before it was taken");

	a_status_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_PRESENT) && present) || ((status == ST_NOT_FOUND) &&
			!present) || ((status == ST_FULL) && !present) || (status == ST_OK))
		else $error("status disagrees with present");

	a_anon_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(anonymous_seen))
		else $error("anonymous flag cleared");

endmodule

bind lbts_clock_table lbts_checker u_lbts_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lbts_clock_table participant clock table.
// A directed table covers empty, full-range and anonymous cases. Random phases
// then vary own_handle, handle pool size and operation mix. Typed rows give
// their own result; others match an in-bench copy of the table and its bound.
// ----------------------------------------------------------------------------
module tb;
	import lbts_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES      = 8;
	localparam int PHASE_REQS  = 236;
	localparam int POOL_MAX    = 48;
	localparam logic [TIME_W-1:0] MAX_TIME = INF_TIME - 1;

	typedef struct packed {
		status_t             st;
		logic                pres;
		logic [TIME_W-1:0]   lb;
		logic                anon;
	} lbts_result_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] hnd;
		logic [TIME_W-1:0]   tval;
		logic                typed;
		lbts_result_t        want;
	} clock_row_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [HANDLE_W-1:0] cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [1:0]          operation   = OP_QUERY;
	logic [HANDLE_W-1:0] handle      = '0;
	logic [TIME_W-1:0]   time_value  = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [1:0]          status;
	logic                present;
	logic [TIME_W-1:0]   lower_bound;
	logic                anonymous_seen;

	logic                tbl_used [TABLE_DEPTH];
	logic [HANDLE_W-1:0] tbl_hnd  [TABLE_DEPTH];
	logic [TIME_W-1:0]   tbl_clk  [TABLE_DEPTH];
	logic [TIME_W-1:0]   bound_now = INF_TIME;
	logic                anon_now  = 1'b0;
	logic [HANDLE_W-1:0] own_now   = '0;

	lbts_result_t awaited_q [$];
	int           errors  = 0;
	bit           idle_on = 1'b1;

	clock_row_t dir_rows [21] = '{
		'{OP_QUERY,  16'h0005, 48'h1234,           1'b1, '{ST_OK,        1'b0, INF_TIME,     1'b0}},
		'{OP_UPDATE, 16'h0005, 48'h1,              1'b1, '{ST_NOT_FOUND, 1'b0, INF_TIME,     1'b0}},
		'{OP_REMOVE, 16'h0005, 48'h0,              1'b1, '{ST_NOT_FOUND, 1'b0, INF_TIME,     1'b0}},
		'{OP_INSERT, 16'hFFFF, MAX_TIME,           1'b1, '{ST_OK,        1'b0, MAX_TIME,     1'b0}},
		'{OP_INSERT, 16'hFFFF, 48'h0,              1'b1, '{ST_PRESENT,   1'b1, MAX_TIME,     1'b0}},
		'{OP_INSERT, 16'h0000, 48'h0,              1'b1, '{ST_OK,        1'b0, MAX_TIME,     1'b0}},
		'{OP_INSERT, 16'h0001, 48'h1_8000,         1'b1, '{ST_OK,        1'b0, 48'h1_8000,   1'b0}},
		'{OP_UPDATE, 16'h0001, 48'h1_0000,         1'b1, '{ST_OK,        1'b1, 48'h1_8000,   1'b0}},
		'{OP_UPDATE, 16'h0001, 48'h2_0000,         1'b1, '{ST_OK,        1'b1, 48'h2_0000,   1'b0}},
		'{OP_INSERT, 16'h0002, 48'h0,              1'b1, '{ST_OK,        1'b0, 48'h0,        1'b0}},
		'{OP_UPDATE, 16'h0000, 48'h3_0000,         1'b1, '{ST_OK,        1'b1, 48'h3_0000,   1'b1}},
		'{OP_QUERY,  16'h0000, 48'h0,              1'b1, '{ST_OK,        1'b1, 48'h3_0000,   1'b1}},
		'{OP_REMOVE, 16'h0001, 48'h0,              1'b1, '{ST_OK,        1'b1, 48'h3_0000,   1'b1}},
		'{OP_UPDATE, 16'h0002, MAX_TIME,           1'b1, '{ST_OK,        1'b1, MAX_TIME,     1'b1}},
		'{OP_REMOVE, 16'h0002, 48'h0,              1'b1, '{ST_OK,        1'b1, MAX_TIME,     1'b1}},
		'{OP_REMOVE, 16'hFFFF, 48'h0,              1'b1, '{ST_OK,        1'b1, INF_TIME,     1'b1}},
		'{OP_UPDATE, 16'h0000, 48'h0,              1'b1, '{ST_OK,        1'b1, INF_TIME,     1'b1}},
		'{OP_REMOVE, 16'h0000, 48'h0,              1'b1, '{ST_OK,        1'b1, INF_TIME,     1'b1}},
		'{OP_UPDATE, 16'h0000, 48'h5,              1'b1, '{ST_OK,        1'b0, INF_TIME,     1'b1}},
		'{OP_INSERT, 16'hA5C3, 48'h5A5A_C3C3_0F0F, 1'b0, '{ST_OK,        1'b0, INF_TIME,     1'b0}},
		'{OP_QUERY,  16'h5A3C, 48'hA5A5_3C3C_F0F0, 1'b0, '{ST_OK,        1'b0, INF_TIME,     1'b0}}
	};

	lbts_clock_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.handle         (handle),
		.time_value     (time_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.present        (present),
		.lower_bound    (lower_bound),
		.anonymous_seen (anonymous_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_used[i] = 1'b0;
			tbl_hnd[i]  = '0;
			tbl_clk[i]  = '0;
		end
	end

	function automatic lbts_result_t advance_table(op_t op, logic [HANDLE_W-1:0] h,
			logic [TIME_W-1:0] t);
		lbts_result_t r;
		int hit;
		int slot;
		int i;
		hit  = -1;
		slot = -1;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			if (hit < 0 && tbl_used[i] && tbl_hnd[i] == h)
				hit = i;
			if (slot < 0 && !tbl_used[i])
				slot = i;
		end
		r.st = ST_OK;
		case (op)
			OP_INSERT: begin
				if (hit >= 0)
					r.st = ST_PRESENT;
				else if (slot < 0)
					r.st = ST_FULL;
				else begin
					tbl_used[slot] = 1'b1;
					tbl_hnd[slot]  = h;
					tbl_clk[slot]  = t;
				end
			end
			OP_UPDATE: begin
				if (h == ANON_HANDLE) begin
					anon_now = 1'b1;
					for (i = 0; i < TABLE_DEPTH; i++)
						if (tbl_used[i] && tbl_clk[i] <= t)
							tbl_clk[i] = t;
				end else if (hit < 0)
					r.st = ST_NOT_FOUND;
				else if (tbl_clk[hit] <= t)
					tbl_clk[hit] = t;
			end
			OP_REMOVE: begin
				if (hit < 0)
					r.st = ST_NOT_FOUND;
				else
					tbl_used[hit] = 1'b0;
			end
			default: ;
		endcase
		bound_now = INF_TIME;
		for (i = 0; i < TABLE_DEPTH; i++)
			if (tbl_used[i] && tbl_hnd[i] != own_now && tbl_clk[i] < bound_now)
				bound_now = tbl_clk[i];
		r.pres = (hit >= 0);
		r.lb   = bound_now;
		r.anon = anon_now;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
			logic [TIME_W-1:0] want);
		$display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_result();
		lbts_result_t e;
		if (awaited_q.size() == 0) begin
			report_mismatch("result without request", 48'(status), '0);
			return;
		end
		e = awaited_q.pop_front();
		if (status !== e.st)
			report_mismatch("status", 48'(status), 48'(e.st));
		if (present !== e.pres)
			report_mismatch("present", 48'(present), 48'(e.pres));
		if (lower_bound !== e.lb)
			report_mismatch("lower_bound", lower_bound, e.lb);
		if (anonymous_seen !== e.anon)
			report_mismatch("anonymous_seen", 48'(anonymous_seen), 48'(e.anon));
	endtask

	task automatic drive_request(op_t op, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] t,
			logic typed, lbts_result_t want);
		int gap;
		lbts_result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		handle     <= h;
		time_value <= t;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		r = advance_table(op, h, t);
		if (typed)
			r = want;
		awaited_q = {awaited_q, r};
	endtask

	// drain all results, then allow the worst-case scan latency
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic set_own_handle(logic [HANDLE_W-1:0] v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		own_now = v;
	endtask

	initial begin : result_sink
		int hold;
		int got;
		hold = 0;
		got  = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				check_result();
				got++;
				// long hold-off so the table backs up and stalls requests
				if (got == 150 || got == 1100)
					hold = 400;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					hold = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t timeout, %0d results outstanding", $time, awaited_q.size());
		$display("lbts_clock_table test failed");
		$finish;
	end

	initial begin : stimulus
		logic [HANDLE_W-1:0] pool [POOL_MAX];
		logic [HANDLE_W-1:0] own;
		logic [HANDLE_W-1:0] h;
		logic [TIME_W-1:0]   t;
		lbts_result_t        none;
		op_t                 op;
		int                  pool_n;
		int                  fill_bias;
		int                  r;
		none = '{ST_OK, 1'b0, INF_TIME, 1'b0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_own_handle(ANON_HANDLE);
		foreach (dir_rows[i])
			drive_request(dir_rows[i].op, dir_rows[i].hnd, dir_rows[i].tval,
				dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0:       own = 16'hFFFF;
				1:       own = 16'($urandom());
				2:       own = ANON_HANDLE;
				default: own = 16'($urandom_range(1, 65534));
			endcase
			set_own_handle(own);
			idle_on   = (p % 3 != 2);
			pool_n    = 6 << (p % 4);
			fill_bias = (p % 4 == 1 || p % 4 == 3);
			pool[0]   = own;
			for (int i = 1; i < POOL_MAX; i++)
				pool[i] = 16'($urandom());

			for (int n = 0; n < PHASE_REQS; n++) begin
				r = $urandom_range(0, 99);
				if (fill_bias)
					op = (r < 60) ? OP_INSERT : (r < 80) ? OP_UPDATE :
						(r < 90) ? OP_REMOVE : OP_QUERY;
				else
					op = (r < 30) ? OP_INSERT : (r < 60) ? OP_UPDATE :
						(r < 85) ? OP_REMOVE : OP_QUERY;

				r = $urandom_range(0, 99);
				if (r < 4)
					h = ANON_HANDLE;
				else if (r < 8)
					h = 16'($urandom());
				else if (r < 10)
					h = 16'hFFFF;
				else
					h = pool[$urandom_range(0, pool_n - 1)];

				r = $urandom_range(0, 99);
				if (r < 5)
					t = '0;
				else if (r < 12)
					t = MAX_TIME;
				else begin
					t = 48'({$urandom(), $urandom()}) >> $urandom_range(0, 40);
					if (t == INF_TIME)
						t = MAX_TIME;
				end
				drive_request(op, h, t, 1'b0, none);
			end
		end

		settle();
		if (errors == 0)
			$display("lbts_clock_table test passed");
		else
			$display("lbts_clock_table test failed");
		$finish;
	end

endmodule
